[rtl/dzvd_pkg.sv]
// dzvd_pkg: shared constants and types for the delta zigzag varint decoder
// no dependencies; used by every module under rtl

package dzvd_pkg;

  // varint framing
  localparam int unsigned MaxGroups    = 10;
  localparam int unsigned GroupBits    = 7;
  localparam int unsigned ValueWidth   = 64;
  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned GroupIdxW    = 4;
  localparam int unsigned ShiftW       = 6;

  // chunk configuration
  localparam int unsigned ChunkWidth   = 16;
  localparam logic [ChunkWidth-1:0] ChunkLengthReset = 16'd256;

  // default depth of the queue between front and back
  localparam int unsigned QueueDepthDefault = 4;

  // one finished varint as handed from front to back
  typedef struct packed {
    logic                  valid;
    logic [ValueWidth-1:0] varint;
  } varint_item_t;

  // zigzag mapping back to a two's complement delta
  function automatic logic [ValueWidth-1:0] zigzag_to_delta(input logic [ValueWidth-1:0] z);
    zigzag_to_delta = (z >> 1) ^ {ValueWidth{z[0]}};
  endfunction

endpackage

[rtl/dzvd_front.sv]
// dzvd_front: accepts encoded bytes and gathers 7-bit groups into a varint
// depends on dzvd_pkg; pushes each finished varint into dzvd_queue

module dzvd_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [dzvd_pkg::ByteWidth-1:0]       data_byte,
  input  logic                                 byte_valid,
  output logic                                 byte_ready,
  input  logic                                 queue_full,
  output dzvd_pkg::varint_item_t               push
);

  logic [dzvd_pkg::ValueWidth-1:0] partial;
  logic [dzvd_pkg::ValueWidth-1:0] partial_next;
  logic [dzvd_pkg::GroupIdxW-1:0]  group_index;
  logic [dzvd_pkg::ShiftW-1:0]     pos;
  logic [dzvd_pkg::ValueWidth-1:0] group_shifted;
  logic                            take;
  logic                            last_byte;

  assign byte_ready = !queue_full;
  assign take       = byte_valid && byte_ready;

  // bit position of this group; the tenth group keeps only bit 0 at bit 63
  assign pos = dzvd_pkg::ShiftW'(group_index) * dzvd_pkg::ShiftW'(dzvd_pkg::GroupBits);
  assign group_shifted =
    {{(dzvd_pkg::ValueWidth-dzvd_pkg::GroupBits){1'b0}}, data_byte[dzvd_pkg::GroupBits-1:0]} << pos;
  assign partial_next = partial | group_shifted;

  // varint ends on a clear continuation bit or on the last allowed group
  assign last_byte = !data_byte[dzvd_pkg::ByteWidth-1] ||
                     (group_index == dzvd_pkg::GroupIdxW'(dzvd_pkg::MaxGroups - 1));

  assign push.valid  = take && last_byte;
  assign push.varint = partial_next;

  // gather state
  always_ff @(posedge clk) begin
    if (rst) begin
      partial     <= '0;
      group_index <= '0;
    end else if (take) begin
      if (last_byte) begin
        partial     <= '0;
        group_index <= '0;
      end else begin
        partial     <= partial_next;
        group_index <= group_index + dzvd_pkg::GroupIdxW'(1);
      end
    end
  end

endmodule

[rtl/dzvd_queue.sv]
// dzvd_queue: small fifo of finished varints between front and back
// depends on dzvd_pkg

module dzvd_queue #(
  parameter int unsigned DEPTH = dzvd_pkg::QueueDepthDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dzvd_pkg::varint_item_t            push,
  output logic                              full,
  input  logic                              pop,
  output dzvd_pkg::varint_item_t            head
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [dzvd_pkg::ValueWidth-1:0] mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full        = (count == CntW'(DEPTH));
  assign do_push     = push.valid && !full;
  assign do_pop      = pop && (count != '0);
  assign head.valid  = (count != '0);
  assign head.varint = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.varint;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

[rtl/dzvd_back.sv]
// dzvd_back: zigzag decode, running sum, chunk counting and output register
// depends on dzvd_pkg; takes varints from dzvd_queue

module dzvd_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [dzvd_pkg::ChunkWidth-1:0]      cfg_wdata,
  input  dzvd_pkg::varint_item_t               head,
  output logic                                 pop,
  output logic signed [dzvd_pkg::ValueWidth-1:0] decoded_value,
  output logic                                 chunk_end,
  output logic                                 result_valid,
  input  logic                                 result_ready
);

  logic [dzvd_pkg::ChunkWidth-1:0] chunk_length;
  logic [dzvd_pkg::ValueWidth-1:0] running_sum;
  logic [dzvd_pkg::ValueWidth-1:0] sum_next;
  logic [dzvd_pkg::ChunkWidth-1:0] values_in_chunk;
  logic [dzvd_pkg::ChunkWidth:0]   count_next;
  logic [dzvd_pkg::ChunkWidth:0]   limit;
  logic                            last;

  // take a varint whenever the output register is free or being drained
  assign pop = head.valid && (!result_valid || result_ready);

  assign sum_next   = running_sum + dzvd_pkg::zigzag_to_delta(head.varint);
  assign count_next = {1'b0, values_in_chunk} + (dzvd_pkg::ChunkWidth+1)'(1);
  // zero length means a full 16-bit wrap of values
  assign limit = (chunk_length == '0) ? {1'b1, {dzvd_pkg::ChunkWidth{1'b0}}}
                                      : {1'b0, chunk_length};
  assign last  = (count_next >= limit);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_length <= dzvd_pkg::ChunkLengthReset;
    end else if (cfg_we) begin
      chunk_length <= cfg_wdata;
    end
  end

  // running sum and chunk position
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum     <= '0;
      values_in_chunk <= '0;
    end else if (pop) begin
      running_sum     <= last ? '0 : sum_next;
      values_in_chunk <= last ? '0 : count_next[dzvd_pkg::ChunkWidth-1:0];
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      decoded_value <= sum_next;
      chunk_end     <= last;
    end
  end

endmodule

[rtl/delta_zigzag_varint_decoder.sv]
// delta_zigzag_varint_decoder: top level of the varint stream decoder
// depends on dzvd_pkg, dzvd_front, dzvd_queue, dzvd_back

// Decodes a byte stream of LEB128-style varints (7 bits per byte, least
// significant group first, up to ten bytes, only bit 0 of a tenth group kept),
// zigzag-maps each varint to a signed delta and emits the running sum of the
// deltas as a 64-bit two's complement value. The sum restarts at zero after
// chunk_length values (0 means 65536) and chunk_end marks the last value of
// each chunk. One byte is taken per clock cycle while the queue is not full;
// the varint's final byte is written into the queue, and the back's single
// 64-bit add then moves its sum into the output register once that register
// is free or being drained. The QUEUE_DEPTH-entry queue lets the byte side
// keep running while the result side stalls, until the queue fills. Write
// chunk_length only while idle.

module delta_zigzag_varint_decoder #(
  parameter int unsigned QUEUE_DEPTH = dzvd_pkg::QueueDepthDefault
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [dzvd_pkg::ChunkWidth-1:0]        cfg_wdata,
  input  logic [dzvd_pkg::ByteWidth-1:0]         data_byte,
  input  logic                                   byte_valid,
  output logic                                   byte_ready,
  output logic signed [dzvd_pkg::ValueWidth-1:0] decoded_value,
  output logic                                   chunk_end,
  output logic                                   result_valid,
  input  logic                                   result_ready
);

  dzvd_pkg::varint_item_t push;
  dzvd_pkg::varint_item_t head;
  logic                   queue_full;
  logic                   pop;

  // byte gathering
  dzvd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (data_byte),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .queue_full (queue_full),
    .push       (push)
  );

  // decoupling queue
  dzvd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (queue_full),
    .pop  (pop),
    .head (head)
  );

  // delta accumulation and output
  dzvd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .head          (head),
    .pop           (pop),
    .decoded_value (decoded_value),
    .chunk_end     (chunk_end),
    .result_valid  (result_valid),
    .result_ready  (result_ready)
  );

endmodule

[tb/tb_delta_zigzag_varint_decoder.sv]
// tb_delta_zigzag_varint_decoder: self-checking testbench for the varint stream decoder
// depends on dzvd_pkg and delta_zigzag_varint_decoder, which brings in dzvd_front, dzvd_queue and dzvd_back
// byte queue driver, result monitor and a per-byte running-sum predictor

`timescale 1ns / 1ps

module tb_delta_zigzag_varint_decoder;

  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 8;

  // one decoded value as the block should present it
  typedef struct {
    logic [dzvd_pkg::ValueWidth-1:0] sum;
    logic                            last;
  } sum_rec_t;

  logic                                   clk;
  logic                                   rst;
  logic                                   cfg_we;
  logic [dzvd_pkg::ChunkWidth-1:0]        cfg_wdata;
  logic [dzvd_pkg::ByteWidth-1:0]         data_byte;
  logic                                   byte_valid;
  logic                                   byte_ready;
  logic signed [dzvd_pkg::ValueWidth-1:0] decoded_value;
  logic                                   chunk_end;
  logic                                   result_valid;
  logic                                   result_ready;

  delta_zigzag_varint_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .data_byte    (data_byte),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .decoded_value(decoded_value),
    .chunk_end    (chunk_end),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

  // predictor state
  logic [dzvd_pkg::ValueWidth-1:0] sum_acc;
  logic [dzvd_pkg::ValueWidth-1:0] varint_acc;
  int                              group_cnt;
  int                              chunk_count;
  logic [dzvd_pkg::ChunkWidth-1:0] chunk_len;

  logic [dzvd_pkg::ByteWidth-1:0] byte_q[$];
  sum_rec_t                       expected_sums[$];

  logic byte_taken;
  logic quiet;
  int   send_gap;
  int   recv_stall;
  int   cycles;
  int   errors;
  int   bytes_sent;
  int   values_seen;
  int   chunk_ends_seen;
  int   settings_used;

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // running-sum prediction for one transferred byte
  task automatic decode_byte(input logic [dzvd_pkg::ByteWidth-1:0] b);
    int                              pos;
    int                              limit;
    logic [dzvd_pkg::ValueWidth-1:0] delta;
    sum_rec_t                        rec;
    pos = dzvd_pkg::GroupBits * group_cnt;
    if (pos < dzvd_pkg::ValueWidth) begin
      varint_acc = varint_acc |
        ({{(dzvd_pkg::ValueWidth-dzvd_pkg::GroupBits){1'b0}},
          b[dzvd_pkg::GroupBits-1:0]} << pos);
    end
    group_cnt++;
    if (!b[dzvd_pkg::ByteWidth-1] || group_cnt >= dzvd_pkg::MaxGroups) begin
      delta = (varint_acc >> 1) ^
              ({dzvd_pkg::ValueWidth{1'b0}} -
               {{(dzvd_pkg::ValueWidth-1){1'b0}}, varint_acc[0]});
      sum_acc = sum_acc + delta;
      varint_acc = '0;
      group_cnt = 0;
      limit = (chunk_len == '0) ? 65536 : int'(chunk_len);
      rec.sum = sum_acc;
      rec.last = (chunk_count + 1 >= limit);
      expected_sums.push_back(rec);
      if (rec.last) begin
        sum_acc = '0;
        chunk_count = 0;
      end else begin
        chunk_count = (chunk_count + 1) % 65536;
      end
    end
  endtask

  // byte driver: a new byte goes out only after the previous transfer
  always @(negedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || byte_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        byte_valid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        data_byte <= byte_q.pop_front();
        byte_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 15) == 0) begin
          send_gap = $urandom_range(1, 12);
        end
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (recv_stall > 0) begin
      recv_stall--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 11) == 0) begin
        recv_stall = $urandom_range(1, 12);
      end
    end
  end

  // monitor: result check, byte prediction and the cycle limit
  always @(posedge clk) begin
    sum_rec_t exp_rec;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    byte_taken <= !rst && byte_valid && byte_ready;
    if (!rst && result_valid && result_ready) begin
      values_seen++;
      if (chunk_end) begin
        chunk_ends_seen++;
      end
      if (expected_sums.size() == 0) begin
        $error("unexpected result transfer: decoded_value %0d chunk_end %0b",
               decoded_value, chunk_end);
        errors++;
      end else begin
        exp_rec = expected_sums.pop_front();
        if (decoded_value !== exp_rec.sum) begin
          $error("decoded_value: expected %0d, actual %0d", $signed(exp_rec.sum), decoded_value);
          errors++;
        end
        if (chunk_end !== exp_rec.last) begin
          $error("chunk_end: expected %0b, actual %0b", exp_rec.last, chunk_end);
          errors++;
        end
      end
    end
    if (!rst && byte_valid && byte_ready) begin
      bytes_sent++;
      decode_byte(data_byte);
    end
  end

  // one whole varint, sometimes with stray random bytes ahead of it
  task automatic add_varint(inout int planned);
    int                             len;
    int                             r;
    int                             k;
    logic [dzvd_pkg::ByteWidth-1:0] b;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      k = $urandom_range(1, 6);
      repeat (k) begin
        byte_q.push_back(8'($urandom_range(0, 255)));
        planned++;
      end
    end
    r = $urandom_range(0, 99);
    if (r < 35) len = 1;
    else if (r < 60) len = $urandom_range(2, 3);
    else if (r < 85) len = $urandom_range(4, 9);
    else len = dzvd_pkg::MaxGroups;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0) b = 8'h00;
      else if (r == 1) b = 8'h7f;
      else b = 8'($urandom_range(0, 127));
      if (i < len - 1) begin
        b[dzvd_pkg::ByteWidth-1] = 1'b1;
      end else if (len == dzvd_pkg::MaxGroups) begin
        // tenth byte ends the varint whatever its top bit says
        b[dzvd_pkg::ByteWidth-1] = 1'($urandom_range(0, 1));
      end
      byte_q.push_back(b);
      planned++;
    end
  endtask

  task automatic fill_random(input int target);
    int planned;
    planned = 0;
    while (planned < target) begin
      add_varint(planned);
    end
  endtask

  // wait for every queued byte and every expected value, then let the block settle
  task automatic drain();
    while (byte_q.size() != 0 || byte_valid || expected_sums.size() != 0) begin
      @(negedge clk);
    end
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_chunk_length(input logic [dzvd_pkg::ChunkWidth-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    chunk_len = v;
    settings_used++;
  endtask

  initial begin
    logic [dzvd_pkg::ChunkWidth-1:0] lowered;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    data_byte = '0;
    byte_valid = 1'b0;
    result_ready = 1'b0;
    byte_taken = 1'b0;
    quiet = 1'b0;
    send_gap = 0;
    recv_stall = 0;
    cycles = 0;
    errors = 0;
    bytes_sent = 0;
    values_seen = 0;
    chunk_ends_seen = 0;
    settings_used = 1;
    sum_acc = '0;
    varint_acc = '0;
    group_cnt = 0;
    chunk_count = 0;
    chunk_len = dzvd_pkg::ChunkLengthReset;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: zero and minus one deltas, largest one-byte group, two-byte varint
    byte_q.push_back(8'h00);
    byte_q.push_back(8'h01);
    byte_q.push_back(8'h7f);
    byte_q.push_back(8'h80);
    byte_q.push_back(8'h01);
    // all-ones ten-byte varint, tenth byte still marked as continuing
    repeat (dzvd_pkg::MaxGroups) byte_q.push_back(8'hff);
    // empty groups up to the tenth, whose upper group bits are dropped
    repeat (dzvd_pkg::MaxGroups - 1) byte_q.push_back(8'h80);
    byte_q.push_back(8'h7f);

    // default chunk length from reset, with a full stop of the sender halfway
    fill_random(125);
    drain();
    fill_random(125);
    drain();

    // every value closes a chunk
    write_chunk_length(16'd1);
    fill_random(200);
    drain();

    // zero acts as the longest chunk
    write_chunk_length(16'd0);
    fill_random(250);
    drain();

    write_chunk_length(16'd300);
    fill_random(250);
    drain();

    // shorten below what the current chunk already holds, or to one for a short chunk
    lowered = (chunk_count > 1) ? dzvd_pkg::ChunkWidth'(chunk_count - 1) : 16'd1;
    write_chunk_length(lowered);
    fill_random(200);
    drain();

    // largest explicit length, no idling on either side
    write_chunk_length(16'hffff);
    quiet = 1'b1;
    fill_random(300);
    drain();

    $display("run covered %0d bytes and %0d values (%0d chunk ends) over %0d chunk lengths",
             bytes_sent, values_seen, chunk_ends_seen, settings_used);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/dzvd_pkg.sv
rtl/dzvd_front.sv
rtl/dzvd_queue.sv
rtl/dzvd_back.sv
rtl/delta_zigzag_varint_decoder.sv
tb/tb_delta_zigzag_varint_decoder.sv
